FILE: rtl/uart_frame_receiver_top_macros.svh
// Assertion macros used by the checker file of the UART frame receiver.
// No dependencies; include with the bare file name.
`ifndef UART_FRAME_RECEIVER_TOP_MACROS_SVH
`define UART_FRAME_RECEIVER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ufr_pkg.sv
// Types, codes, constants and the CRC-8 table of the UART frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package ufr_pkg;

  localparam int unsigned SyncLimit = 32;
  localparam int unsigned PadBytes  = 6;
  localparam logic [7:0]  SyncByte  = 8'hAA;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxPayload = 1'b0,
    CfgPadEnable  = 1'b1
  } cfg_idx_e;

  typedef enum logic [6:0] {
    PhHunt  = 7'b0000001,
    PhCtrl  = 7'b0000010,
    PhLenHi = 7'b0000100,
    PhLenLo = 7'b0001000,
    PhCrc   = 7'b0010000,
    PhData  = 7'b0100000,
    PhPad   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    EvData  = 2'd0,
    EvDone  = 2'd1,
    EvError = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ErrSync = 3'd0,
    ErrSeq  = 3'd1,
    ErrCrc  = 3'd2,
    ErrLen  = 3'd3,
    ErrPad  = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic        padding_enable;
  } cfg_t;

  localparam logic [7:0] CrcTable [256] = '{
    8'h00,8'h91,8'he3,8'h72,8'h07,8'h96,8'he4,8'h75,
    8'h0e,8'h9f,8'hed,8'h7c,8'h09,8'h98,8'hea,8'h7b,
    8'h1c,8'h8d,8'hff,8'h6e,8'h1b,8'h8a,8'hf8,8'h69,
    8'h12,8'h83,8'hf1,8'h60,8'h15,8'h84,8'hf6,8'h67,
    8'h38,8'ha9,8'hdb,8'h4a,8'h3f,8'hae,8'hdc,8'h4d,
    8'h36,8'ha7,8'hd5,8'h44,8'h31,8'ha0,8'hd2,8'h43,
    8'h24,8'hb5,8'hc7,8'h56,8'h23,8'hb2,8'hc0,8'h51,
    8'h2a,8'hbb,8'hc9,8'h58,8'h2d,8'hbc,8'hce,8'h5f,
    8'h70,8'he1,8'h93,8'h02,8'h77,8'he6,8'h94,8'h05,
    8'h7e,8'hef,8'h9d,8'h0c,8'h79,8'he8,8'h9a,8'h0b,
    8'h6c,8'hfd,8'h8f,8'h1e,8'h6b,8'hfa,8'h88,8'h19,
    8'h62,8'hf3,8'h81,8'h10,8'h65,8'hf4,8'h86,8'h17,
    8'h48,8'hd9,8'hab,8'h3a,8'h4f,8'hde,8'hac,8'h3d,
    8'h46,8'hd7,8'ha5,8'h34,8'h41,8'hd0,8'ha2,8'h33,
    8'h54,8'hc5,8'hb7,8'h26,8'h53,8'hc2,8'hb0,8'h21,
    8'h5a,8'hcb,8'hb9,8'h28,8'h5d,8'hcc,8'hbe,8'h2f,
    8'he0,8'h71,8'h03,8'h92,8'he7,8'h76,8'h04,8'h95,
    8'hee,8'h7f,8'h0d,8'h9c,8'he9,8'h78,8'h0a,8'h9b,
    8'hfc,8'h6d,8'h1f,8'h8e,8'hfb,8'h6a,8'h18,8'h89,
    8'hf2,8'h63,8'h11,8'h80,8'hf5,8'h64,8'h16,8'h87,
    8'hd8,8'h49,8'h3b,8'haa,8'hdf,8'h4e,8'h3c,8'had,
    8'hd6,8'h47,8'h35,8'ha4,8'hd1,8'h40,8'h32,8'ha3,
    8'hc4,8'h55,8'h27,8'hb6,8'hc3,8'h52,8'h20,8'hb1,
    8'hca,8'h5b,8'h29,8'hb8,8'hcd,8'h5c,8'h2e,8'hbf,
    8'h90,8'h01,8'h73,8'he2,8'h97,8'h06,8'h74,8'he5,
    8'h9e,8'h0f,8'h7d,8'hec,8'h99,8'h08,8'h7a,8'heb,
    8'h8c,8'h1d,8'h6f,8'hfe,8'h8b,8'h1a,8'h68,8'hf9,
    8'h82,8'h13,8'h61,8'hf0,8'h85,8'h14,8'h66,8'hf7,
    8'ha8,8'h39,8'h4b,8'hda,8'haf,8'h3e,8'h4c,8'hdd,
    8'ha6,8'h37,8'h45,8'hd4,8'ha1,8'h30,8'h42,8'hd3,
    8'hb4,8'h25,8'h57,8'hc6,8'hb3,8'h22,8'h50,8'hc1,
    8'hba,8'h2b,8'h59,8'hc8,8'hbd,8'h2c,8'h5e,8'hcf
  };

  function automatic logic [7:0] crc_step(input logic [7:0] idx);
    return CrcTable[idx];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ufr_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Payload type is a parameter; the item types come from ufr_pkg.
`default_nettype none

interface ufr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/ufr_cfg_regs.sv
// Configuration registers of the UART frame receiver (max payload, padding).
// Depends on ufr_pkg.
`default_nettype none

module ufr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ufr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ufr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output ufr_pkg::cfg_t                  cfg_o
);
  import ufr_pkg::*;

  logic [15:0] max_payload_q, max_payload_d;
  logic        pad_en_q, pad_en_d;

  always_comb begin
    max_payload_d = max_payload_q;
    pad_en_d      = pad_en_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxPayload: max_payload_d = cfg_wdata_i[15:0];
        CfgPadEnable:  pad_en_d      = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= 16'hFFFF;
      pad_en_q      <= 1'b1;
    end else begin
      max_payload_q <= max_payload_d;
      pad_en_q      <= pad_en_d;
    end
  end

  assign cfg_o.max_payload    = max_payload_q;
  assign cfg_o.padding_enable = pad_en_q;

endmodule

`default_nettype wire

FILE: rtl/ufr_in_stage.sv
// Input register of the UART frame receiver: holds one received byte.
// Depends on ufr_pkg.
`default_nettype none

module ufr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ufr_pkg::in_item_t item_i,
  output logic              ready_o,
  input  logic              advance_i,
  output logic              valid_o,
  output logic [7:0]        byte_o
);
  import ufr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  // The register can refill in the same cycle it hands its byte on.
  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= item_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

FILE: rtl/ufr_parser.sv
// Frame parser of the UART frame receiver: sync hunt, header check, payload
// and padding tracking, one byte per step. Depends on ufr_pkg.
`default_nettype none

module ufr_parser #(
  parameter int unsigned SYNC_LIMIT = ufr_pkg::SyncLimit
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  ufr_pkg::cfg_t      cfg_i,
  output logic               emit_o,
  output ufr_pkg::out_item_t item_o
);
  import ufr_pkg::*;

  localparam int unsigned MissW = $clog2(SYNC_LIMIT + 1);

  phase_e           phase_q, phase_d;
  logic [3:0]       seq_q, seq_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       ctrl_q, ctrl_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [MissW-1:0] miss_q, miss_d;

  logic        pad_on;
  logic [7:0]  crc_next;
  logic [15:0] cnt_inc;
  logic [1:0]  ev;
  logic [7:0]  ob;
  logic [2:0]  err;

  assign pad_on   = cfg_i.padding_enable && (PadBytes > 0);
  assign crc_next = crc_step(byte_i ^ crc_q);
  assign cnt_inc  = cnt_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    seq_d   = seq_q;
    crc_d   = crc_q;
    ctrl_d  = ctrl_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    miss_d  = miss_q;
    emit_o  = 1'b0;
    ev      = EvData;
    ob      = 8'h00;
    err     = ErrSync;

    unique case (phase_q)
      PhCtrl: begin
        ctrl_d = byte_i;
        len_d  = 16'h0000;
        if (byte_i[3:0] != seq_q) begin
          emit_o = 1'b1;
          ev     = EvError;
          err    = ErrSeq;
        end else begin
          crc_d   = crc_step(byte_i);
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        len_d   = {byte_i, 8'h00};
        crc_d   = crc_next;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {len_q[15:8], byte_i};
        crc_d   = crc_next;
        phase_d = PhCrc;
      end
      PhCrc: begin
        crc_d = crc_next;
        if (crc_next != 8'h00) begin
          emit_o = 1'b1;
          ev     = EvError;
          err    = ErrCrc;
        end else if (len_q > cfg_i.max_payload) begin
          emit_o = 1'b1;
          ev     = EvError;
          err    = ErrLen;
        end else begin
          cnt_d = 16'h0000;
          if (len_q != 16'h0000) begin
            phase_d = PhData;
          end else if (pad_on) begin
            phase_d = PhPad;
          end else begin
            emit_o = 1'b1;
            ev     = EvDone;
          end
        end
      end
      PhData: begin
        emit_o = 1'b1;
        ob     = byte_i;
        if (cnt_inc < len_q) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = 16'h0000;
          if (pad_on) begin
            phase_d = PhPad;
          end else begin
            ev = EvDone;
          end
        end
      end
      PhPad: begin
        if (byte_i != 8'h00) begin
          emit_o = 1'b1;
          ev     = EvError;
          err    = ErrPad;
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 16'(PadBytes)) begin
            emit_o = 1'b1;
            ev     = EvDone;
          end
        end
      end
      default: begin
        // Hunting; an unused phase code behaves the same way.
        phase_d = PhHunt;
        if (byte_i == SyncByte) begin
          miss_d  = '0;
          phase_d = PhCtrl;
        end else if (miss_q >= MissW'(SYNC_LIMIT)) begin
          ctrl_d = 8'h00;
          len_d  = 16'h0000;
          emit_o = 1'b1;
          ev     = EvError;
          err    = ErrSync;
        end else begin
          miss_d = miss_q + MissW'(1);
        end
      end
    endcase

    // Both a completed frame and an error send the parser back to hunting.
    if (emit_o && (ev != EvData)) begin
      phase_d = PhHunt;
      cnt_d   = 16'h0000;
      miss_d  = '0;
      if (ev == EvDone) begin
        seq_d = seq_q + 4'd1;
      end
    end

    item_o.event_res    = ev;
    item_o.out_byte     = ob;
    item_o.frame_type   = ctrl_d;
    item_o.frame_length = len_d;
    item_o.error_code   = (ev == EvError) ? err : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      seq_q   <= 4'd0;
      crc_q   <= 8'h00;
      ctrl_q  <= 8'h00;
      len_q   <= 16'h0000;
      cnt_q   <= 16'h0000;
      miss_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      crc_q   <= crc_d;
      ctrl_q  <= ctrl_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      miss_q  <= miss_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ufr_out_stage.sv
// Result register of the UART frame receiver, drained by the result channel.
// Depends on ufr_pkg.
`default_nettype none

module ufr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ufr_pkg::out_item_t item_i,
  input  logic               ready_i,
  output logic               valid_o,
  output ufr_pkg::out_item_t item_o,
  output logic               can_take_o
);
  import ufr_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign can_take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: rtl/uart_frame_receiver_top.sv
// UART frame receiver. A byte accepted into the input register passes the parser
// into the result register; header and padding bytes give an item only on an error
// or at the end of a frame. Throughput: one byte per cycle; a result item
// waiting on the result channel holds the input register, header bytes included.
// Reset (asynchronous, active low) empties both registers, returns the parser
// to hunting with sequence number zero and restores max_payload and padding.
`default_nettype none

module uart_frame_receiver_top #(
  parameter int unsigned SYNC_LIMIT = ufr_pkg::SyncLimit
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ufr_stream_if.sink                   rx_i,
  ufr_stream_if.source                 res_o,
  input  logic                         cfg_we_i,
  input  logic [ufr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ufr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ufr_pkg::*;

  cfg_t      cfg;
  logic      in_valid;
  logic [7:0] in_byte;
  logic      can_take;
  logic      step;
  logic      emit;
  out_item_t step_item;
  out_item_t res_item;
  logic      res_valid;
  logic      rx_ready;

  assign step = in_valid && can_take;

  ufr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ufr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .item_i    (rx_i.payload),
    .ready_o   (rx_ready),
    .advance_i (step),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  ufr_parser #(
    .SYNC_LIMIT (SYNC_LIMIT)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .cfg_i  (cfg),
    .emit_o (emit),
    .item_o (step_item)
  );

  ufr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && emit),
    .item_i     (step_item),
    .ready_i    (res_o.ready),
    .valid_o    (res_valid),
    .item_o     (res_item),
    .can_take_o (can_take)
  );

  assign rx_i.ready    = rx_ready;
  assign res_o.valid   = res_valid;
  assign res_o.payload = res_item;

endmodule

`default_nettype wire

FILE: rtl/ufr_checker.sv
// Port-level checks of the UART frame receiver result channel, bound to the
// top level. Depends on ufr_pkg and uart_frame_receiver_top_macros.svh.
`default_nettype none

`include "uart_frame_receiver_top_macros.svh"

module ufr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input ufr_pkg::out_item_t res_payload_i
);
  import ufr_pkg::*;

  `UFR_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_payload_i), "stalled result item changed")
  `UFR_ASSERT_IMPL(a_err_code_zero, clk_i, rst_ni, res_valid_i && (res_payload_i.event_res != EvError), res_payload_i.error_code == 3'd0, "error code set without error")
  `UFR_ASSERT_IMPL(a_data_has_len, clk_i, rst_ni, res_valid_i && (res_payload_i.event_res == EvData), res_payload_i.frame_length != 16'h0000, "payload byte in empty frame")
  `UFR_ASSERT_IMPL(a_sync_err_clear, clk_i, rst_ni, res_valid_i && (res_payload_i.event_res == EvError) && (res_payload_i.error_code == ErrSync), (res_payload_i.frame_type == 8'h00) && (res_payload_i.frame_length == 16'h0000), "sync timeout carries header fields")

endmodule

bind uart_frame_receiver_top ufr_checker u_ufr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

`default_nettype wire
